[rtl/pra_pkg.sv]
`default_nettype none
// Shared codes and types of the page run allocator.
package pra_pkg;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_BADSIZE = 2'd3;

   // Fit policies.
   localparam logic [1:0] FIT_NEXT  = 2'd0;
   localparam logic [1:0] FIT_FIRST = 2'd1;
   localparam logic [1:0] FIT_BEST  = 2'd2;
   localparam logic [1:0] FIT_WORST = 2'd3;

   // Register indexes of the configuration port.
   localparam logic REG_FIT_MODE  = 1'b0;
   localparam logic REG_HEAP_BASE = 1'b1;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Control from the sequencer to the hole tracker.
   typedef struct packed {
      logic init;     // restart the run count at a new scan origin
      logic step;     // one page is presented
      logic free_pg;  // the presented page is free
   } trk_ctl_type;

endpackage
`default_nettype wire

[rtl/pra_track.sv]
`default_nettype none
// Tracks free runs over a page scan and keeps the run chosen by the fit policy.
module pra_track #(
   parameter int NUM_PAGES = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire pra_pkg::trk_ctl_type        ctl,
   input  wire [1:0]                        mode,
   input  wire [$clog2(NUM_PAGES+1)-1:0]    need,
   input  wire [$clog2(NUM_PAGES+1)-1:0]    lo,
   input  wire [$clog2(NUM_PAGES+1)-1:0]    idx,
   output logic                             found,
   output logic [$clog2(NUM_PAGES)-1:0]     first
);

   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int AW = $clog2(NUM_PAGES);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] beg_ff, beg_in;
   logic [CW-1:0] best_len_ff, best_len_in;
   logic [AW-1:0] best_beg_ff, best_beg_in;
   logic          found_ff, found_in;
   logic          stop;
   logic          take;

   // Next fit and first fit settle on the first run; later pages are ignored.
   assign stop = found_ff && (mode == pra_pkg::FIT_NEXT || mode == pra_pkg::FIT_FIRST);

   always_comb begin
      cnt_in      = cnt_ff;
      beg_in      = beg_ff;
      best_len_in = best_len_ff;
      best_beg_in = best_beg_ff;
      found_in    = found_ff;
      take        = 1'b0;
      if (ctl.init) begin
         cnt_in      = '0;
         beg_in      = lo;
         best_len_in = '0;
         found_in    = 1'b0;
      end else if (ctl.step && !stop) begin
         if (mode == pra_pkg::FIT_NEXT) begin
            if (ctl.free_pg) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == need) begin
                  found_in    = 1'b1;
                  best_beg_in = beg_ff[AW-1:0];
               end
            end else begin
               cnt_in = '0;
               beg_in = idx + 1'b1;
            end
         end else begin
            if (ctl.free_pg) begin
               if (cnt_ff == '0) begin
                  beg_in = idx;
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               // A hole closes here; weigh it against the best one so far.
               if (cnt_ff >= need) begin
                  take = !found_ff
                       || (mode == pra_pkg::FIT_BEST  && cnt_ff < best_len_ff)
                       || (mode == pra_pkg::FIT_WORST && cnt_ff > best_len_ff);
               end
               if (take) begin
                  found_in    = 1'b1;
                  best_len_in = cnt_ff;
                  best_beg_in = beg_ff[AW-1:0];
               end
               cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      cnt_ff      <= cnt_in;
      beg_ff      <= beg_in;
      best_len_ff <= best_len_in;
      best_beg_ff <= best_beg_in;
   end

   assign found = found_ff;
   assign first = best_beg_ff;

endmodule
`default_nettype wire

[rtl/page_run_allocator_unit.sv]
`default_nettype none
// Page run allocator.
//
//   channel  direction  ports        content
//   req      in         req_t*       tuser: op; tdata: size_bytes, free_address
//   rsp      out        rsp_t*       tdata: status, address, pages
//   csr      in         csr_*        index 0 fit_mode, index 1 heap_base
//
// After reset the page table is swept clear in S_CLEAR; no word is
// accepted during the sweep. An allocation reads the page table once per page
// through the single read port in S_SCAN; next fit, which may restart from
// page 0, still reads each page at most once. Then S_MARK writes each
// allocated page and S_DONE hands on the result. A free reads its start page
// in S_FREE_RD and clears the run in S_RELEASE. The result register lets a
// new word be accepted while the previous result waits on rsp_tready.
module page_run_allocator_unit #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096   // a power of two
) (
   input  wire         clock,
   input  wire         reset,
   // Request words.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire         req_tuser,        // op
   input  wire  [55:0] req_tdata,        // size_bytes[22:0], free_address[54:23]
   // Result words.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,        // status[1:0], address[33:2], pages[44:34]
   // Register writes.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [31:0] csr_data
);

   localparam int CW     = $clog2(NUM_PAGES + 1);
   localparam int AW     = $clog2(NUM_PAGES);
   localparam int PB_LOG = $clog2(PAGE_BYTES);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_END     = 4'd3;
   localparam logic [3:0] S_END_CHK = 4'd4;
   localparam logic [3:0] S_MARK    = 4'd5;
   localparam logic [3:0] S_FREE_RD = 4'd6;
   localparam logic [3:0] S_RELEASE = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   // Page table: bit 1 page used, bit 0 start of a run. Run lengths beside it.
   logic [1:0]    pg_mem  [NUM_PAGES];
   logic [CW-1:0] len_mem [NUM_PAGES];

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic          phase_ff, phase_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] need_ff, need_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [1:0]    fit_mode_ff, fit_mode_in;
   logic [31:0]   heap_base_ff, heap_base_in;
   logic [AW-1:0] mark_ff, mark_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] first_ff, first_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic [CW-1:0] res_pages_ff, res_pages_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    mem_q_ff;
   logic [CW-1:0] len_q_ff;

   logic          pg_we, len_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    pg_wd;
   logic [CW-1:0] trk_lo, trk_idx;
   logic [1:0]    trk_mode;
   pra_pkg::trk_ctl_type trk_ctl;
   logic          trk_found;
   logic [AW-1:0] trk_first;

   logic          req_take;
   logic [22:0]   size_bytes;
   logic [31:0]   free_address;
   logic [23:0]   size_sum, need_wide;
   logic [31:0]   free_off, free_pg;
   logic [63:0]   run_off;
   logic          load_rsp;

   assign size_bytes   = req_tdata[22:0];
   assign free_address = req_tdata[54:23];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_take     = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;

   // Pages for a request, rounded up; page index of a free address.
   assign size_sum  = {1'b0, size_bytes} + 24'(PAGE_BYTES - 1);
   assign need_wide = size_sum >> PB_LOG;
   assign free_off  = free_address - heap_base_ff;
   assign free_pg   = free_off >> PB_LOG;
   assign run_off   = 64'(first_ff) << PB_LOG;

   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   pra_track #(
      .NUM_PAGES (NUM_PAGES)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .ctl   (trk_ctl),
      .mode  (trk_mode),
      .need  (need_ff),
      .lo    (trk_lo),
      .idx   (trk_idx),
      .found (trk_found),
      .first (trk_first)
   );

   assign trk_mode = mode_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      hi_in         = hi_ff;
      phase_in      = phase_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_ff[AW-1:0];
      need_in       = need_ff;
      mode_in       = mode_ff;
      ptr_in        = ptr_ff;
      fit_mode_in   = fit_mode_ff;
      heap_base_in  = heap_base_ff;
      mark_in       = mark_ff;
      left_in       = left_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_pages_in  = res_pages_ff;
      pg_we         = 1'b0;
      len_we        = 1'b0;
      wr_addr       = mark_ff;
      pg_wd         = 2'b00;
      rd_addr       = scan_ff[AW-1:0];
      trk_ctl       = '0;
      trk_lo        = '0;
      trk_idx       = CW'(rd_idx_ff);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            pra_pkg::REG_FIT_MODE:  fit_mode_in  = csr_data[1:0];
            pra_pkg::REG_HEAP_BASE: heap_base_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            pg_we   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = free_pg[AW-1:0];
            if (req_take) begin
               res_addr_in  = '0;
               res_pages_in = '0;
               if (req_tuser == pra_pkg::OP_ALLOC) begin
                  if (size_bytes == '0 || need_wide > 24'(NUM_PAGES)) begin
                     res_status_in = pra_pkg::ST_BADSIZE;
                     state_in      = S_DONE;
                  end else begin
                     need_in     = CW'(need_wide);
                     mode_in     = fit_mode_ff;
                     phase_in    = 1'b0;
                     hi_in       = CW'(NUM_PAGES);
                     trk_ctl.init = 1'b1;
                     if (fit_mode_ff == pra_pkg::FIT_NEXT) begin
                        trk_lo  = ptr_ff;
                        scan_in = ptr_ff;
                     end else begin
                        scan_in = '0;
                     end
                     state_in = S_SCAN;
                  end
               end else begin
                  if (free_pg < 32'(NUM_PAGES)) begin
                     mark_in  = free_pg[AW-1:0];
                     state_in = S_FREE_RD;
                  end else begin
                     res_status_in = pra_pkg::ST_UNKNOWN;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_SCAN: begin
            // One page read is issued per cycle; its bits are seen in the next cycle.
            trk_ctl.step    = rd_vld_ff;
            trk_ctl.free_pg = !mem_q_ff[1];
            if (trk_found && (mode_ff == pra_pkg::FIT_NEXT || mode_ff == pra_pkg::FIT_FIRST))
            begin
               first_in = trk_first;
               mark_in  = trk_first;
               left_in  = need_ff;
               state_in = S_MARK;
            end else if (scan_ff >= hi_ff) begin
               if (!rd_vld_ff) begin
                  if (mode_ff != pra_pkg::FIT_NEXT) begin
                     state_in = S_END;
                  end else if (!phase_ff) begin
                     // Second pass of next fit: page 0 up to the old pointer.
                     phase_in     = 1'b1;
                     hi_in        = ptr_ff;
                     scan_in      = '0;
                     trk_ctl.step = 1'b0;
                     trk_ctl.init = 1'b1;
                  end else begin
                     ptr_in        = '0;
                     res_status_in = pra_pkg::ST_NOSPACE;
                     state_in      = S_DONE;
                  end
               end
            end else begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end
         end
         S_END: begin
            // The end of the heap closes the last hole like a used page.
            trk_ctl.step = 1'b1;
            trk_idx      = CW'(NUM_PAGES);
            state_in     = S_END_CHK;
         end
         S_END_CHK: begin
            if (trk_found) begin
               first_in = trk_first;
               mark_in  = trk_first;
               left_in  = need_ff;
               state_in = S_MARK;
            end else begin
               res_status_in = pra_pkg::ST_NOSPACE;
               state_in      = S_DONE;
            end
         end
         S_MARK: begin
            pg_we   = 1'b1;
            pg_wd   = {1'b1, mark_ff == first_ff};
            len_we  = (mark_ff == first_ff);
            mark_in = mark_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == CW'(1)) begin
               res_status_in = pra_pkg::ST_OK;
               res_addr_in   = heap_base_ff + run_off[31:0];
               res_pages_in  = need_ff;
               if (mode_ff == pra_pkg::FIT_NEXT) begin
                  ptr_in = CW'(first_ff) + need_ff;
               end
               state_in = S_DONE;
            end
         end
         S_FREE_RD: begin
            if (!mem_q_ff[0]) begin
               res_status_in = pra_pkg::ST_UNKNOWN;
               state_in      = S_DONE;
            end else begin
               left_in       = len_q_ff;
               res_pages_in  = len_q_ff;
               res_status_in = pra_pkg::ST_OK;
               state_in      = S_RELEASE;
            end
         end
         S_RELEASE: begin
            pg_we   = 1'b1;
            pg_wd   = 2'b00;
            mark_in = mark_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == CW'(1) || mark_ff == AW'(NUM_PAGES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, 11'(res_pages_ff), res_addr_ff, res_status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         ptr_ff       <= '0;
         fit_mode_ff  <= pra_pkg::FIT_NEXT;
         heap_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         ptr_ff       <= ptr_in;
         fit_mode_ff  <= fit_mode_in;
         heap_base_ff <= heap_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      hi_ff         <= hi_in;
      phase_ff      <= phase_in;
      rd_idx_ff     <= rd_idx_in;
      need_ff       <= need_in;
      mode_ff       <= mode_in;
      mark_ff       <= mark_in;
      left_ff       <= left_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_pages_ff  <= res_pages_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Page table and run length memories, one write and one read port each.
   always_ff @(posedge clock) begin
      if (pg_we) begin
         pg_mem[wr_addr] <= pg_wd;
      end
      if (len_we) begin
         len_mem[wr_addr] <= need_ff;
      end
      mem_q_ff <= pg_mem[rd_addr];
      len_q_ff <= len_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The scan only reads; nothing may be written while pages are being read.
   a_scan_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !pg_we)
      else $error("page table written during a scan");

   // A failed or free result never carries an address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && res_status_ff != pra_pkg::ST_OK) |-> (res_addr_ff == '0))
      else $error("address reported on a failed request");

   // The scan address never runs past the end of its range.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= hi_ff))
      else $error("scan address beyond range");

   // A marked run is never empty when marking starts.
   a_mark_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (left_ff != '0))
      else $error("marking with no pages left");
`endif

endmodule
`default_nettype wire

[test/page_run_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
// Watches the request, result and register channels of the allocator, keeps its own
// page table, and compares every result word with the oldest prediction.
module page_run_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire         req_tuser,
   input  wire  [55:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [47:0] rsp_tdata,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire         csr_index,
   input  wire  [31:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          alloc_granted
);
   localparam int NP = 1024;
   localparam int PB = 4096;

   // Same bit order as the result word: status in the lowest bits.
   typedef struct packed {
      logic [10:0] pages;
      logic [31:0] address;
      logic [1:0]  status;
   } alloc_result_type;

   alloc_result_type outcome_q[$];
   bit          page_used [NP];
   bit          run_start [NP];
   logic [10:0] run_len   [NP];
   int          next_ptr;
   logic [1:0]  fit_mode;
   logic [31:0] heap_base;

   assign pending = outcome_q.size();

   // Lowest run of n free pages inside [lo, hi).
   function automatic bit scan_span(int lo, int hi, int n, output int hole_first,
                                    output int hole_last);
      int count;
      int begin_pg;
      count = 0;
      begin_pg = lo;
      hole_first = 0;
      hole_last = 0;
      for (int i = lo; i < hi && i < NP; i++) begin
         if (!page_used[i]) count++;
         else begin
            count = 0;
            begin_pg = i + 1;
         end
         if (count == n) begin
            hole_first = begin_pg;
            hole_last = i;
            return 1;
         end
      end
      return 0;
   endfunction

   // Walks the maximal holes and picks one by policy; ties keep the lower hole.
   function automatic bit pick_hole(logic [1:0] mode, int n, output int hole_first);
      int  len;
      int  begin_pg;
      int  best;
      bit  found;
      bit  take;
      len = 0;
      begin_pg = 0;
      best = 0;
      found = 0;
      hole_first = 0;
      for (int i = 0; i <= NP; i++) begin
         if (i < NP && !page_used[i]) begin
            if (len == 0) begin_pg = i;
            len++;
         end else begin
            if (len >= n && len > 0) begin
               if (!found) take = 1;
               else if (mode == pra_pkg::FIT_BEST) take = len < best;
               else if (mode == pra_pkg::FIT_WORST) take = len > best;
               else take = 0;
               if (take) begin
                  found = 1;
                  best = len;
                  hole_first = begin_pg;
                  if (mode == pra_pkg::FIT_FIRST) return 1;
               end
            end
            len = 0;
         end
      end
      return found;
   endfunction

   function automatic alloc_result_type predict_word(logic op, logic [22:0] size,
                                                     logic [31:0] faddr);
      alloc_result_type r;
      int            n;
      int            hole_first;
      int            hole_last;
      int            old;
      bit            ok;
      logic [31:0]   off;
      logic [31:0]   idx;
      r = '0;
      r.status = pra_pkg::ST_OK;
      if (op == pra_pkg::OP_ALLOC) begin
         n = (int'(size) + PB - 1) / PB;
         if (size == 0 || n > NP) r.status = pra_pkg::ST_BADSIZE;
         else begin
            if (fit_mode == pra_pkg::FIT_NEXT) begin
               old = next_ptr;
               ok = scan_span(old, NP, n, hole_first, hole_last);
               if (!ok) begin
                  next_ptr = 0;
                  ok = scan_span(0, old, n, hole_first, hole_last);
               end
               if (ok) next_ptr = hole_last + 1;
            end else begin
               ok = pick_hole(fit_mode, n, hole_first);
            end
            if (ok) begin
               for (int k = 0; k < n && hole_first + k < NP; k++)
                  page_used[hole_first + k] = 1;
               run_start[hole_first] = 1;
               run_len[hole_first] = n[10:0];
               r.address = heap_base + 32'(hole_first) * 32'(PB);
               r.pages = n[10:0];
            end else r.status = pra_pkg::ST_NOSPACE;
         end
      end else begin
         off = faddr - heap_base;
         idx = off / 32'(PB);
         if (idx >= 32'(NP) || !run_start[idx]) r.status = pra_pkg::ST_UNKNOWN;
         else begin
            for (int k = 0; k < int'(run_len[idx]) && int'(idx) + k < NP; k++)
               page_used[int'(idx) + k] = 0;
            run_start[idx] = 0;
            r.pages = run_len[idx];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         for (int i = 0; i < NP; i++) begin
            page_used[i] = 0;
            run_start[i] = 0;
            run_len[i] = '0;
         end
         next_ptr = 0;
         fit_mode = pra_pkg::FIT_NEXT;
         heap_base = '0;
         outcome_q.delete();
         fail_count = 0;
         alloc_granted = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pra_pkg::REG_FIT_MODE) fit_mode = csr_data[1:0];
            else heap_base = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[44:0];
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word %h", $realtime, got);
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch status %0d/%0d address %h/%h pages %0d/%0d",
                              $realtime, want.status, got.status, want.address,
                              got.address, want.pages, got.pages);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_word(req_tuser, req_tdata[22:0], req_tdata[54:23]);
            if (req_tuser == pra_pkg::OP_ALLOC && want.status == pra_pkg::ST_OK)
               alloc_granted++;
            outcome_q.push_back(want);
         end
      end
   end
endmodule
`default_nettype wire

[test/tb_page_run_allocator_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
// Stimulus and verdict for the page run allocator. The checker beside the block does
// all prediction; this module only produces words and decides pass or fail.
module tb_page_run_allocator_unit;

   localparam int WATCH_LIMIT = 20000;  // reset sweep plus the longest allocation, with margin
   localparam int PB = 4096;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   wire         req_tready;
   logic        req_tuser = pra_pkg::OP_ALLOC;
   logic [55:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1;
   wire  [47:0] rsp_tdata;
   logic        csr_valid = 0;
   wire         csr_ready;
   logic        csr_index = pra_pkg::REG_FIT_MODE;
   logic [31:0] csr_data = '0;

   int fail_count;
   int pending;
   int alloc_granted;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int watch_count = 0;

   // Addresses of live allocations, learned from the result words, used to build frees.
   logic [31:0] live_addr[$];
   logic        op_sent[$];
   logic [31:0] cur_base = '0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   page_run_allocator_unit DUT (.*);

   page_run_checker checker_i (.*);

   // The receiver stalls at random, changing its ready at the falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Track which result words belong to granted allocations.
   always @(posedge clock) begin
      logic was_alloc;
      if (!reset && rsp_tvalid && rsp_tready && op_sent.size() > 0) begin
         was_alloc = op_sent.pop_front();
         if (was_alloc == pra_pkg::OP_ALLOC && rsp_tdata[1:0] == pra_pkg::ST_OK)
            live_addr.push_back(rsp_tdata[33:2]);
      end
      if (!reset && req_tvalid && req_tready) op_sent.push_back(req_tuser);
   end

   // The watchdog ends a run in which no channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         watch_count <= 0;
      else
         watch_count <= watch_count + 1;
      if (watch_count == WATCH_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // One request word, held until the block takes it. The sender may idle first.
   // The word is raised at a falling edge after the previous one was dropped.
   task automatic send_word(logic op, logic [22:0] size, logic [31:0] faddr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, faddr, size};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // Wait for every outstanding result, then let the block rest before returning.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      if (idx == pra_pkg::REG_HEAP_BASE) begin
         cur_base = value;
         live_addr.delete();
      end
   endtask

   // Random word: mostly allocations of a few pages and frees of live runs, with
   // some noise such as bad sizes and addresses that do not start a run.
   task automatic random_word();
      int          pick;
      int          k;
      logic [22:0] size;
      logic [31:0] faddr;
      pick = $urandom_range(99);
      if (pick < 52) begin
         if ($urandom_range(99) < 4) size = 23'($urandom_range(4194304, 1));
         else size = 23'($urandom_range(16 * PB, 1));
         send_word(pra_pkg::OP_ALLOC, size, $urandom);
      end else if (pick < 92 && live_addr.size() > 0) begin
         k = $urandom_range(live_addr.size() - 1);
         faddr = live_addr[k] + $urandom_range(PB - 1);
         live_addr.delete(k);
         send_word(pra_pkg::OP_FREE, 23'($urandom), faddr);
      end else if (pick < 95) begin
         faddr = cur_base + $urandom_range(1023) * PB;
         send_word(pra_pkg::OP_FREE, 23'($urandom), ($urandom_range(1)) ? faddr : $urandom);
      end else begin
         size = ($urandom_range(1)) ? 23'd0 : 23'($urandom_range(8388607, 4194305));
         send_word(pra_pkg::OP_ALLOC, size, $urandom);
      end
   endtask

   initial begin
      logic [31:0] bases[4];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: next fit with the heap at address zero.
      write_reg(pra_pkg::REG_FIT_MODE, 32'(pra_pkg::FIT_NEXT));
      write_reg(pra_pkg::REG_HEAP_BASE, 32'h0);
      send_word(pra_pkg::OP_ALLOC, 23'd0, '0);              // zero size
      send_word(pra_pkg::OP_ALLOC, 23'h7FFFFF, '1);         // far oversize
      send_word(pra_pkg::OP_ALLOC, 23'd4194305, '0);        // one page too many
      send_word(pra_pkg::OP_ALLOC, 23'd1, '0);              // one page at page 0
      send_word(pra_pkg::OP_ALLOC, 23'd4097, '0);           // two pages at page 1
      send_word(pra_pkg::OP_FREE, '0, 32'h0000_1800);       // inside the start page rounds down
      send_word(pra_pkg::OP_FREE, '0, 32'h0000_1000);       // already released
      send_word(pra_pkg::OP_FREE, '0, 32'hFFFF_FFFF);       // far outside the heap
      send_word(pra_pkg::OP_FREE, '0, 32'h0000_2000);       // a released page, not a run start
      send_word(pra_pkg::OP_ALLOC, 23'd4194304, '0);        // whole heap does not fit
      send_word(pra_pkg::OP_FREE, '0, 32'h0);
      send_word(pra_pkg::OP_ALLOC, 23'd4194304, '0);        // whole heap, pointer goes to the end
      send_word(pra_pkg::OP_ALLOC, 23'd1, '0);              // no space at all
      send_word(pra_pkg::OP_FREE, '0, 32'h0);
      send_word(pra_pkg::OP_ALLOC, 23'd4096, '0);           // the last failure reset the pointer to page 0
      send_word(pra_pkg::OP_FREE, '0, 32'h0);
      // The sender pauses here until every result is back.
      drain();
      // A heap near the top of the address space: addresses wrap, low frees miss.
      write_reg(pra_pkg::REG_HEAP_BASE, 32'hFFFF_F000);
      write_reg(pra_pkg::REG_FIT_MODE, 32'(pra_pkg::FIT_WORST));
      send_word(pra_pkg::OP_ALLOC, 23'd8192, '0);
      send_word(pra_pkg::OP_FREE, '0, 32'h0000_0000);
      send_word(pra_pkg::OP_FREE, '0, 32'hFFFF_E000);       // below the heap base
      send_word(pra_pkg::OP_ALLOC, 23'd100, '0);
      drain();

      // Random phases, each setting a policy, a base and an idling pattern.
      bases = '{32'h0, 32'hFFFF_F000, 32'h8000_0000, 32'h1234_5000};
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         write_reg(pra_pkg::REG_FIT_MODE, 32'(phase % 4));
         write_reg(pra_pkg::REG_HEAP_BASE,
                   (phase == 7) ? ($urandom & 32'hFFFF_F000) : bases[phase / 2]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         // Runs left by earlier phases stay allocated and narrow the free space.
         for (int i = 0; i < 69; i++) random_word();
      end

      send_idle_pct = 0;
      while (pending != 0) @(negedge clock);
      repeat (2200) @(negedge clock);
      stall_pct = 0;
      $display("Sent %0d request words over all four fit policies and idling patterns;",
               words_sent);
      $display("%0d allocations were granted, with frees, misses and bad sizes between.",
               alloc_granted);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
